// ----- hdl/strided_view_bounds_checker_defines.svh -----
// Assertion macros for the strided view bounds checker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef STRIDED_VIEW_BOUNDS_CHECKER_DEFINES_SVH
`define STRIDED_VIEW_BOUNDS_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SVBC_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svbc: implication check failed");

// Next-cycle implication, disabled during reset
`define SVBC_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svbc: next-cycle check failed");

`else

`define SVBC_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)
`define SVBC_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons)

`endif

`endif

// ----- hdl/svbc_pkg.sv -----
// Shared types and constants for the strided view bounds checker.
// No dependencies; used by every module of the block.
package svbc_pkg;

  localparam int DATA_W = 64;
  localparam int FLAGS_W = 8;
  localparam int FLAG_PINNED_BIT = 1;
  localparam int FLAG_KNOWN_BITS = 3;

  // Request modes
  typedef enum logic [1:0] {
    MODE_VALIDATE = 2'd0,
    MODE_SLICE    = 2'd1,
    MODE_INDEX    = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  // Diagnostic codes
  typedef enum logic [2:0] {
    DIAG_NONE       = 3'd0,
    DIAG_INVALID    = 3'd1,
    DIAG_GENERATION = 3'd2,
    DIAG_LIFETIME   = 3'd3,
    DIAG_BOUNDS     = 3'd4,
    DIAG_OVERFLOW   = 3'd5
  } diag_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BASE_OFFSET   = 3'd0,
    REG_ELEMENT_COUNT = 3'd1,
    REG_STRIDE_BYTES  = 3'd2,
    REG_ELEMENT_BYTES = 3'd3,
    REG_VIEW_FLAGS    = 3'd4,
    REG_OWNER_PRESENT = 3'd5,
    REG_STORAGE_GEN   = 3'd6,
    REG_LIFETIME_SET  = 3'd7
  } cfg_reg_t;

  // View descriptor as held in the configuration registers
  typedef struct packed {
    logic [DATA_W-1:0]  base_offset;
    logic [DATA_W-1:0]  element_count;
    logic [DATA_W-1:0]  stride_bytes;
    logic [DATA_W-1:0]  element_bytes;
    logic [FLAGS_W-1:0] view_flags;
    logic               owner_present;
    logic [DATA_W-1:0]  storage_generation;
    logic               lifetime_set;
  } view_t;

endpackage

// ----- hdl/strided_view_bounds_checker.sv -----
// Strided view bounds checker: top level with the check pipeline.
// Depends on svbc_pkg, svbc_cfg_regs, svbc_mul64 and the assertion macro header.
//
// Usage
//   Configuration: write the view descriptor through cfg_we / cfg_index /
//   cfg_wdata while no transaction is in flight; a write lands at the clock
//   edge where cfg_we is high.
//   Requests: drive in_* and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. busy is high only during reset.
//   Results: each request yields exactly one result, shown on the out_* ports
//   for one cycle with out_valid high. The receiver cannot hold results off.
// Throughput and pipeline
//   Results come out one per cycle at full rate. The six register stages
//   are: capture, three stages of the partial-product multipliers for the
//   last element index and the access operand times stride, the base
//   offset add, and the element size add with the final check selection.
// Reset
//   Synchronous active-low reset clears the descriptor to zero and drops all
//   transactions in flight.
`include "strided_view_bounds_checker_defines.svh"

module strided_view_bounds_checker #(
  parameter int ADDR_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [svbc_pkg::DATA_W-1:0] in_current_generation,
  input  logic [svbc_pkg::DATA_W-1:0] in_slice_start,
  input  logic [svbc_pkg::DATA_W-1:0] in_slice_length,
  input  logic signed [svbc_pkg::DATA_W-1:0] in_element_index,
  // configuration port
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [svbc_pkg::DATA_W-1:0] cfg_wdata,
  // result channel
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [2:0]                  out_diag_code,
  output logic [svbc_pkg::DATA_W-1:0] out_diag_expected,
  output logic [svbc_pkg::DATA_W-1:0] out_diag_actual,
  output logic [svbc_pkg::DATA_W-1:0] out_offset,
  output logic [svbc_pkg::DATA_W-1:0] out_length
);

  localparam int DW = svbc_pkg::DATA_W;
  localparam int PW = 2 * svbc_pkg::DATA_W;
  localparam logic [DW-1:0] ADDR_MAX = {DW{1'b1}} >> (DW - ADDR_WIDTH);
  localparam logic [DW:0]   ADDR_MAX_SUM = {1'b0, ADDR_MAX};
  localparam logic [PW-1:0] ADDR_MAX_PROD = {{DW{1'b0}}, ADDR_MAX};

  // Sideband carried alongside the multiplier
  typedef struct packed {
    svbc_pkg::mode_t mode;
    logic [DW-1:0]   gen;
    logic [DW-1:0]   aop;
    logic [DW-1:0]   len;
    logic            neg;
    logic            rng_bad;
    logic            gen_bad;
  } side_t;

  svbc_pkg::view_t view;

  logic accept;

  // capture stage
  logic            s1_vld_r;
  svbc_pkg::mode_t s1_mode_r;
  logic [DW-1:0]   s1_gen_r;
  logic [DW-1:0]   s1_aop_r;
  logic [DW-1:0]   s1_len_r;
  logic            s1_neg_r;
  logic [DW-1:0]   s1_last_r;
  svbc_pkg::mode_t s1_mode_nxt;
  logic [DW-1:0]   s1_gen_nxt;
  logic [DW-1:0]   s1_aop_nxt;
  logic [DW-1:0]   s1_last_nxt;

  // sideband stages
  logic  s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  side_t s2_r, s3_r, s4_r, s5_r;
  side_t s2_nxt;

  // products
  logic [PW-1:0] desc_prod;
  logic [PW-1:0] acc_prod;

  // offset add stage
  logic [DW:0] s5_dsum_r;
  logic [DW:0] s5_off_r;
  logic        s5_dmul_ovf_r;
  logic        s5_amul_ovf_r;

  // output stage
  logic            out_valid_r;
  svbc_pkg::diag_t out_code_r;
  logic [DW-1:0]   out_exp_r;
  logic [DW-1:0]   out_act_r;
  logic [DW-1:0]   out_off_r;
  logic [DW-1:0]   out_len_r;
  svbc_pkg::diag_t out_code_nxt;
  logic [DW-1:0]   out_exp_nxt;
  logic [DW-1:0]   out_act_nxt;
  logic [DW-1:0]   out_off_nxt;
  logic [DW-1:0]   out_len_nxt;
  logic [DW:0]     span_sum;
  logic            desc_ovf;
  logic            acc_ovf;
  logic            cfg_bad;
  logic            pinned_bad;

  svbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .view      (view)
  );

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Capture: pick the multiplier operand and the last element index
  always_comb begin
    s1_mode_nxt = svbc_pkg::mode_t'(in_mode);
    s1_gen_nxt  = (s1_mode_nxt == svbc_pkg::MODE_VALIDATE) ? in_current_generation : '0;
    s1_aop_nxt  = (s1_mode_nxt == svbc_pkg::MODE_SLICE) ? in_slice_start
                                                         : DW'(unsigned'(in_element_index));
    s1_last_nxt = view.element_count - DW'(view.element_count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= s1_mode_nxt;
    s1_gen_r  <= s1_gen_nxt;
    s1_aop_r  <= s1_aop_nxt;
    s1_len_r  <= in_slice_length;
    s1_neg_r  <= in_element_index[DW-1];
    s1_last_r <= s1_last_nxt;
  end

  // Range and generation compares, in parallel with the first multiply stage
  always_comb begin
    logic start_gt;
    logic len_gt;
    logic idx_ge;
    start_gt       = s1_aop_r > view.element_count;
    len_gt         = s1_len_r > (view.element_count - s1_aop_r);
    idx_ge         = s1_aop_r >= view.element_count;
    s2_nxt.mode    = s1_mode_r;
    s2_nxt.gen     = s1_gen_r;
    s2_nxt.aop     = s1_aop_r;
    s2_nxt.len     = s1_len_r;
    s2_nxt.neg     = s1_neg_r;
    s2_nxt.rng_bad = (s1_mode_r == svbc_pkg::MODE_SLICE) ? (start_gt | len_gt) : idx_ge;
    s2_nxt.gen_bad = (s1_gen_r != '0) && (s1_gen_r != view.storage_generation);
  end

  // Advance valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      out_valid_r <= s5_vld_r;
    end
  end

  // Advance sideband in step with the multipliers
  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s2_r;
    s4_r <= s3_r;
    s5_r <= s4_r;
  end

  // Last element span and access offset, both scaled by the stride
  svbc_mul64 u_mul_desc (
    .clk  (clk),
    .a    (s1_last_r),
    .b    (view.stride_bytes),
    .prod (desc_prod)
  );

  svbc_mul64 u_mul_acc (
    .clk  (clk),
    .a    (s1_aop_r),
    .b    (view.stride_bytes),
    .prod (acc_prod)
  );

  // Add the base offset and flag product overflow
  always_ff @(posedge clk) begin
    s5_dmul_ovf_r <= desc_prod > ADDR_MAX_PROD;
    s5_amul_ovf_r <= acc_prod > ADDR_MAX_PROD;
    s5_dsum_r     <= {1'b0, view.base_offset} + {1'b0, desc_prod[DW-1:0]};
    s5_off_r      <= {1'b0, view.base_offset} + {1'b0, acc_prod[DW-1:0]};
  end

  // Add the element size, then select the diagnostic by priority
  always_comb begin
    span_sum   = {1'b0, s5_dsum_r[DW-1:0]} + {1'b0, view.element_bytes};
    desc_ovf   = s5_dmul_ovf_r | (s5_dsum_r > ADDR_MAX_SUM) | (span_sum > ADDR_MAX_SUM);
    acc_ovf    = s5_amul_ovf_r | (s5_off_r > ADDR_MAX_SUM);
    cfg_bad    = (view.stride_bytes == '0) || (view.element_bytes == '0) ||
                 (view.view_flags[svbc_pkg::FLAGS_W-1:svbc_pkg::FLAG_KNOWN_BITS] != '0) ||
                 ((view.element_count != '0) && !view.owner_present);
    pinned_bad = view.view_flags[svbc_pkg::FLAG_PINNED_BIT] && !view.lifetime_set;

    out_code_nxt = svbc_pkg::DIAG_NONE;
    out_exp_nxt  = '0;
    out_act_nxt  = '0;
    out_off_nxt  = '0;
    out_len_nxt  = '0;

    if ((s5_r.mode == svbc_pkg::MODE_UNUSED) || cfg_bad || desc_ovf) begin
      out_code_nxt = svbc_pkg::DIAG_INVALID;
    end else if (s5_r.gen_bad) begin
      out_code_nxt = svbc_pkg::DIAG_GENERATION;
      out_exp_nxt  = s5_r.gen;
      out_act_nxt  = view.storage_generation;
    end else if (pinned_bad) begin
      out_code_nxt = svbc_pkg::DIAG_LIFETIME;
      out_exp_nxt  = DW'(1);
    end else begin
      case (s5_r.mode)
        svbc_pkg::MODE_SLICE: begin
          if (s5_r.rng_bad || acc_ovf) begin
            out_code_nxt = svbc_pkg::DIAG_BOUNDS;
            out_exp_nxt  = view.element_count;
            out_act_nxt  = s5_r.aop;
          end else begin
            out_off_nxt = s5_off_r[DW-1:0];
            out_len_nxt = s5_r.len;
          end
        end
        svbc_pkg::MODE_INDEX: begin
          if (s5_r.neg) begin
            out_code_nxt = svbc_pkg::DIAG_BOUNDS;
            out_exp_nxt  = view.element_count;
          end else if (s5_r.rng_bad || acc_ovf) begin
            out_code_nxt = svbc_pkg::DIAG_OVERFLOW;
            out_exp_nxt  = view.element_count;
            out_act_nxt  = s5_r.aop;
          end else begin
            out_off_nxt = s5_off_r[DW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_exp_r  <= out_exp_nxt;
    out_act_r  <= out_act_nxt;
    out_off_r  <= out_off_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = (out_code_r == svbc_pkg::DIAG_NONE);
  assign out_diag_code     = out_code_r;
  assign out_diag_expected = out_exp_r;
  assign out_diag_actual   = out_act_r;
  assign out_offset        = out_off_r;
  assign out_length        = out_len_r;

  // Checks on the pipeline and result consistency
  `SVBC_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##6 out_valid)
  `SVBC_ASSERT_NXT(a_last_stage, clk, rst_n, s5_vld_r, out_valid)
  `SVBC_ASSERT_IMP(a_pass_no_diag, clk, rst_n, out_valid && out_ok, out_diag_expected == '0 && out_diag_actual == '0)
  `SVBC_ASSERT_IMP(a_len_needs_pass, clk, rst_n, out_valid && out_length != '0, out_ok)
  `SVBC_ASSERT_IMP(a_off_needs_pass, clk, rst_n, out_valid && out_offset != '0, out_ok)

endmodule

// ----- hdl/svbc_cfg_regs.sv -----
// Configuration register file holding the view descriptor.
// Depends on svbc_pkg for the descriptor struct and register indexes.
module svbc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [svbc_pkg::DATA_W-1:0] cfg_wdata,
  output svbc_pkg::view_t             view
);

  svbc_pkg::view_t view_r;
  svbc_pkg::view_t view_nxt;

  // Decode the write into the addressed register
  always_comb begin
    view_nxt = view_r;
    if (cfg_we) begin
      unique case (svbc_pkg::cfg_reg_t'(cfg_index))
        svbc_pkg::REG_BASE_OFFSET:   view_nxt.base_offset = cfg_wdata;
        svbc_pkg::REG_ELEMENT_COUNT: view_nxt.element_count = cfg_wdata;
        svbc_pkg::REG_STRIDE_BYTES:  view_nxt.stride_bytes = cfg_wdata;
        svbc_pkg::REG_ELEMENT_BYTES: view_nxt.element_bytes = cfg_wdata;
        svbc_pkg::REG_VIEW_FLAGS:    view_nxt.view_flags = cfg_wdata[svbc_pkg::FLAGS_W-1:0];
        svbc_pkg::REG_OWNER_PRESENT: view_nxt.owner_present = cfg_wdata[0];
        svbc_pkg::REG_STORAGE_GEN:   view_nxt.storage_generation = cfg_wdata;
        svbc_pkg::REG_LIFETIME_SET:  view_nxt.lifetime_set = cfg_wdata[0];
      endcase
    end
  end

  // Hold the descriptor; reset clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
    end else begin
      view_r <= view_nxt;
    end
  end

  assign view = view_r;

endmodule

// ----- hdl/svbc_mul64.sv -----
// Three-stage pipelined 64x64 unsigned multiplier giving the full product.
// Depends on svbc_pkg for the data width; built from four 32x32 partial products.
module svbc_mul64 (
  input  logic                          clk,
  input  logic [svbc_pkg::DATA_W-1:0]   a,
  input  logic [svbc_pkg::DATA_W-1:0]   b,
  output logic [2*svbc_pkg::DATA_W-1:0] prod
);

  localparam int HALF_W = svbc_pkg::DATA_W / 2;
  localparam int PROD_W = 2 * svbc_pkg::DATA_W;

  logic [svbc_pkg::DATA_W-1:0] pp_ll_r;
  logic [svbc_pkg::DATA_W-1:0] pp_lh_r;
  logic [svbc_pkg::DATA_W-1:0] pp_hl_r;
  logic [svbc_pkg::DATA_W-1:0] pp_hh_r;
  logic [svbc_pkg::DATA_W:0]   mid_r;
  logic [PROD_W-1:0]           cat_r;
  logic [PROD_W-1:0]           prod_r;

  // Stage one: four half-width partial products
  always_ff @(posedge clk) begin
    pp_ll_r <= a[HALF_W-1:0] * b[HALF_W-1:0];
    pp_lh_r <= a[HALF_W-1:0] * b[svbc_pkg::DATA_W-1:HALF_W];
    pp_hl_r <= a[svbc_pkg::DATA_W-1:HALF_W] * b[HALF_W-1:0];
    pp_hh_r <= a[svbc_pkg::DATA_W-1:HALF_W] * b[svbc_pkg::DATA_W-1:HALF_W];
  end

  // Stage two: add the cross terms; low and high terms do not overlap
  always_ff @(posedge clk) begin
    mid_r <= {1'b0, pp_lh_r} + {1'b0, pp_hl_r};
    cat_r <= {pp_hh_r, pp_ll_r};
  end

  // Stage three: fold the cross terms in at the half-word position
  always_ff @(posedge clk) begin
    prod_r <= cat_r + ({{(PROD_W-svbc_pkg::DATA_W-1){1'b0}}, mid_r} << HALF_W);
  end

  assign prod = prod_r;

endmodule
